/* src/pspm_pkg.sv */
// Package for the position/speed plausibility monitor.
// Holds command codes, register indexes and fixed widths; no dependencies.
package pspm_pkg;
  localparam int STAMP_W = 31;
  localparam int SPEED_W = 24;
  localparam int REG_W   = 16;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_SPEED  = 2'd1,
    FUNC_SKIP   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_FACTOR   = 1'b1;
endpackage

/* src/position_speed_plausibility_monitor_top.sv */
// Position/speed plausibility monitor: gates samples by time, measures speed
// by root and divide, tracks threat count and largest excess.
// An evaluated sample passes a setup state, the square-root steps, the quotient steps,
// handoffs and the compare; ignored items skip evaluation. One item at a time: a new
// transfer is taken only once the previous result has left. Synchronous active-low reset
// goes idle, clears history and threat, and loads the default interval and factor.
module position_speed_plausibility_monitor_top import pspm_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic [STAMP_W-1:0]            in_stamp,
  input  logic [SPEED_W-1:0]            in_allowed_speed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_evaluated,
  output logic                          out_violation,
  output logic [SPEED_W-1:0]            out_measured_speed,
  output logic [7:0]                    out_threat_level,
  output logic [SPEED_W-1:0]            out_largest_excess,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [REG_W-1:0]              cfg_data
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int RW = 2 * DW + 2;
  localparam int HW = RW / 2;
  localparam int QW = HW + 10;
  localparam int PW = QW + REG_W;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_DIV, S_CMP, S_OUT} state_t;
  state_t state_r;

  logic [REG_W-1:0] interval_r, factor_r;
  logic [STAMP_W-1:0] prev_stamp_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic [SPEED_W-1:0] prev_allowed_r, allowed_r, max_excess_r;
  logic [7:0] threat_r;
  logic pos_valid_r;
  logic [DW-1:0] dx_r, dy_r;
  logic [31:0] elapsed_r;
  logic [QW-1:0] speed_r;

  logic start_sqrt, start_div, u_done;
  logic [QW-1:0] u_res;
  logic signed [STAMP_W:0] elapsed;
  logic signed [DW-1:0] ddx, ddy;
  logic [2*DW-1:0] sqx, sqy;
  logic [RW-1:0] sq_sum;
  logic [PW-1:0] prod;
  logic [QW-1:0] excess;
  logic late, go_eval;

  pspm_divsqrt #(.RW(RW), .QW(QW)) u_unit (
    .clk, .rst_n, .start_sqrt, .start_div,
    .radicand(sq_sum),
    .dividend(u_res * QW'(1000)),
    .divisor(elapsed_r),
    .done(u_done), .result(u_res)
  );

  always_comb begin
    elapsed = $signed({1'b0, in_stamp}) - $signed({1'b0, prev_stamp_r});
    late = elapsed > $signed({{(STAMP_W-REG_W+1){1'b0}}, interval_r});
    go_eval = (in_func == FUNC_SAMPLE) && late &&
              (in_allowed_speed == prev_allowed_r) && pos_valid_r;
    ddx = DW'(in_pos_x) - DW'(prev_x_r);
    ddy = DW'(in_pos_y) - DW'(prev_y_r);
    sqx = dx_r * dx_r;
    sqy = dy_r * dy_r;
    sq_sum = RW'(sqx) + RW'(sqy);
    prod = PW'(speed_r) * PW'(factor_r);
    excess = speed_r - QW'(allowed_r);
  end

  assign start_sqrt = (state_r == S_SQ);
  assign start_div  = (state_r == S_SQRT) && u_done;
  assign in_ready   = (state_r == S_IDLE) && !out_valid;
  assign cfg_ready  = 1'b1;
  assign out_threat_level   = threat_r;
  assign out_largest_excess = max_excess_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      interval_r <= REG_W'(1000);
      factor_r <= REG_W'(256);
      prev_stamp_r <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_allowed_r <= '0;
      max_excess_r <= '0;
      threat_r <= '0;
      pos_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_INTERVAL) interval_r <= cfg_data;
        else factor_r <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            out_evaluated <= 1'b0;
            out_violation <= 1'b0;
            out_measured_speed <= '0;
            out_valid <= !go_eval;
            case (func_t'(in_func))
              FUNC_SAMPLE: begin
                if (late) begin
                  if (in_allowed_speed != prev_allowed_r) begin
                    prev_allowed_r <= in_allowed_speed;
                  end else if (pos_valid_r) begin
                    dx_r <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
                    dy_r <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
                    elapsed_r <= 32'(elapsed);
                    allowed_r <= in_allowed_speed;
                    state_r <= S_SQ;
                  end
                  prev_stamp_r <= in_stamp;
                  prev_x_r <= in_pos_x;
                  prev_y_r <= in_pos_y;
                  pos_valid_r <= 1'b1;
                end
              end
              FUNC_SPEED: prev_allowed_r <= '0;
              FUNC_SKIP: begin
                if (prev_stamp_r < in_stamp) prev_stamp_r <= in_stamp;
                prev_allowed_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SQ: state_r <= S_SQRT;
        S_SQRT: if (u_done) state_r <= S_DIV;
        S_DIV: if (u_done) begin
          speed_r <= u_res;
          state_r <= S_CMP;
        end
        S_CMP: begin
          out_evaluated <= 1'b1;
          out_measured_speed <= (speed_r > QW'(SPEED_MAX)) ? SPEED_MAX : speed_r[SPEED_W-1:0];
          if (prod > {allowed_r, 8'h00}) begin
            out_violation <= 1'b1;
            if (threat_r != 8'hFF) threat_r <= threat_r + 8'd1;
            if (speed_r > QW'(allowed_r)) begin
              if (excess > QW'(SPEED_MAX)) max_excess_r <= SPEED_MAX;
              else if (excess[SPEED_W-1:0] > max_excess_r)
                max_excess_r <= excess[SPEED_W-1:0];
            end
          end else if (threat_r != 8'd0) begin
            threat_r <= threat_r - 8'd1;
          end
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/pspm_divsqrt.sv */
// Shared iterative unit: bit-serial integer square root and restoring divide.
// Depends on nothing; one root or quotient bit per cycle.
module pspm_divsqrt #(
  parameter int RW = 66,
  parameter int QW = 44
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_sqrt,
  input  logic          start_div,
  input  logic [RW-1:0] radicand,
  input  logic [QW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [QW-1:0] result
);
  localparam int HW = RW / 2;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] work_r;
  logic [QW-1:0] acc_r;
  logic [HW+2:0] rem_r;
  logic [32:0]   drem_r;
  logic [31:0]   dsr_r;
  logic [CW-1:0] cnt_r;
  logic          sq_r, busy_r;

  logic [HW+2:0] sq_rem, sq_trial;
  logic [32:0]   dv_rem;

  always_comb begin
    sq_rem   = {rem_r[HW:0], work_r[RW-1 -: 2]};
    sq_trial = {acc_r[HW:0], 2'b01};
    dv_rem   = {drem_r[31:0], acc_r[QW-1]};
  end

  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start_sqrt || start_div) begin
        busy_r <= 1'b1;
        sq_r   <= start_sqrt;
        work_r <= radicand;
        acc_r  <= start_sqrt ? '0 : dividend;
        rem_r  <= '0;
        drem_r <= '0;
        dsr_r  <= divisor;
        cnt_r  <= start_sqrt ? CW'(HW) : CW'(QW);
      end else if (busy_r) begin
        if (sq_r) begin
          work_r <= {work_r[RW-3:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            rem_r <= sq_rem - sq_trial;
            acc_r <= {acc_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= sq_rem;
            acc_r <= {acc_r[QW-2:0], 1'b0};
          end
        end else begin
          if (dv_rem >= {1'b0, dsr_r}) begin
            drem_r <= dv_rem - {1'b0, dsr_r};
            acc_r  <= {acc_r[QW-2:0], 1'b1};
          end else begin
            drem_r <= dv_rem;
            acc_r  <= {acc_r[QW-2:0], 1'b0};
          end
        end
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end
endmodule

/* bench/tb_position_speed_plausibility_monitor_top.sv */
// Testbench for position_speed_plausibility_monitor_top: directed and random
// items, with an in-bench model of the block and a per-result scoreboard.
// Depends on pspm_pkg and the monitor RTL.
module tb_position_speed_plausibility_monitor_top;
  import pspm_pkg::*;

  localparam int CW         = 24;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic               evaluated;
    logic               violation;
    logic [SPEED_W-1:0] speed;
    logic [7:0]         threat;
    logic [SPEED_W-1:0] excess;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_func = '0;
  logic signed [CW-1:0] in_pos_x = '0;
  logic signed [CW-1:0] in_pos_y = '0;
  logic [STAMP_W-1:0]   in_stamp = '0;
  logic [SPEED_W-1:0]   in_allowed_speed = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_evaluated;
  logic                 out_violation;
  logic [SPEED_W-1:0]   out_measured_speed;
  logic [7:0]           out_threat_level;
  logic [SPEED_W-1:0]   out_largest_excess;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = CFG_INTERVAL;
  logic [REG_W-1:0]     cfg_data = '0;

  position_speed_plausibility_monitor_top #(.COORD_WIDTH(CW)) u_top (.*);

  always #5 clk = ~clk;

  // model state
  logic [REG_W-1:0]     interval_reg;
  logic [REG_W-1:0]     factor_reg;
  logic [STAMP_W-1:0]   mdl_stamp;
  logic signed [CW-1:0] last_x, last_y;
  logic [SPEED_W-1:0]   last_allowed;
  logic [7:0]           threat_cnt;
  logic [SPEED_W-1:0]   peak_excess;
  logic                 have_pos;

  report_t expected_reports[$];
  int  errors = 0;
  int  n_items = 0, n_eval = 0, n_viol = 0, n_cfg = 0;
  bit  quiet = 0;
  bit  hold_rx = 0;
  int  rx_stall = 0;
  int  idle_cycles = 0;

  // stimulus timeline
  logic [STAMP_W-1:0]   now_ms;
  logic signed [CW-1:0] cur_x, cur_y;
  logic [SPEED_W-1:0]   cur_allowed;

  function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[32:0];
  endfunction

  task automatic model_item(input func_t f, input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y,
                            input logic [STAMP_W-1:0] st,
                            input logic [SPEED_W-1:0] al);
    longint elapsed;
    longint unsigned dx, dy, root_len, spd, ex;
    logic [65:0] sq;
    report_t r;
    r = '0;
    case (f)
      FUNC_SAMPLE: begin
        elapsed = longint'(st) - longint'(mdl_stamp);
        if (elapsed > longint'(interval_reg)) begin
          if (al != last_allowed) begin
            last_allowed = al;
          end else if (have_pos) begin
            dx = (longint'(x) >= longint'(last_x)) ? longint'(x) - longint'(last_x)
                                                   : longint'(last_x) - longint'(x);
            dy = (longint'(y) >= longint'(last_y)) ? longint'(y) - longint'(last_y)
                                                   : longint'(last_y) - longint'(y);
            sq   = 66'(dx * dx) + 66'(dy * dy);
            root_len = longint'(floor_sqrt(sq));
            spd  = (root_len * 1000) / longint'(elapsed);
            r.evaluated = 1'b1;
            r.speed = (spd > 64'(SPEED_MAX)) ? SPEED_MAX : spd[SPEED_W-1:0];
            if (spd * longint'(factor_reg) > (longint'(al) << 8)) begin
              r.violation = 1'b1;
              if (threat_cnt != 8'hff) threat_cnt++;
              if (spd > longint'(al)) begin
                ex = spd - longint'(al);
                if (ex > 64'(SPEED_MAX)) ex = 64'(SPEED_MAX);
                if (ex > longint'(peak_excess)) peak_excess = ex[SPEED_W-1:0];
              end
            end else if (threat_cnt != 0) begin
              threat_cnt--;
            end
          end
          mdl_stamp = st;
          last_x     = x;
          last_y     = y;
          have_pos   = 1'b1;
        end
      end
      FUNC_SPEED: last_allowed = '0;
      FUNC_SKIP: begin
        if (mdl_stamp < st) mdl_stamp = st;
        last_allowed = '0;
      end
      default: ;
    endcase
    r.threat = threat_cnt;
    r.excess = peak_excess;
    n_eval += r.evaluated;
    n_viol += r.violation;
    expected_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = expected_reports.pop_front();
        if (out_evaluated !== want.evaluated)
          report_mismatch("evaluated", out_evaluated, want.evaluated);
        if (out_violation !== want.violation)
          report_mismatch("violation", out_violation, want.violation);
        if (out_measured_speed !== want.speed)
          report_mismatch("measured_speed", out_measured_speed, want.speed);
        if (out_threat_level !== want.threat)
          report_mismatch("threat_level", out_threat_level, want.threat);
        if (out_largest_excess !== want.excess)
          report_mismatch("largest_excess", out_largest_excess, want.excess);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_rx) begin
      out_ready = 1'b0;
    end else if (rx_stall > 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0)
        rx_stall = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 4)
                                              : $urandom_range(20, 90);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input func_t f, input logic signed [CW-1:0] x,
                           input logic signed [CW-1:0] y,
                           input logic [STAMP_W-1:0] st,
                           input logic [SPEED_W-1:0] al);
    int gap;
    gap = quiet ? 0 : ($urandom_range(0, 9) < 6) ? 0
        : ($urandom_range(0, 9) < 9) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    if (gap > 0) repeat (gap) @(negedge clk);
    in_func          = f;
    in_pos_x         = x;
    in_pos_y         = y;
    in_stamp         = st;
    in_allowed_speed = al;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
    model_item(f, x, y, st, al);
    n_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    wait (expected_reports.size() == 0);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_INTERVAL) interval_reg = val;
    else factor_reg = val;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // well-timed sample at a fresh stamp
  task automatic timed_sample(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic [SPEED_W-1:0] al, input int extra);
    now_ms = now_ms + STAMP_W'(interval_reg) + STAMP_W'(extra);
    send_item(FUNC_SAMPLE, x, y, now_ms, al);
  endtask

  task automatic test_directed_basics();
    send_item(FUNC_NONE, '1, '1, '1, '1);
    send_item(FUNC_SAMPLE, 24'sd5, 24'sd5, 31'd0, 24'd0);      // equal stamp, ignored
    now_ms = 0;
    timed_sample(24'sd0, 24'sd0, 24'd0, 1);                    // no previous position
    timed_sample(24'sh7fffff, -24'sh800000, 24'd0, 1);
    timed_sample(-24'sh800000, 24'sh7fffff, 24'd0, 1);         // saturated speed and excess
    send_item(FUNC_SPEED, 24'sd0, 24'sd0, 31'd0, 24'd0);
    timed_sample(24'sd0, 24'sd0, 24'd300, 5);                  // re-arm
    timed_sample(24'sd256, 24'sd0, 24'd300, 0);
    timed_sample(24'sd512, 24'sd0, 24'd300, 0);
    send_item(FUNC_SAMPLE, 24'sd1, 24'sd1, now_ms - 31'd50, 24'd300);  // stale
    send_item(FUNC_SKIP, 24'sd0, 24'sd0, now_ms - 31'd10, 24'd0);      // skip lower stamp
    now_ms = now_ms + 31'd4000;
    send_item(FUNC_SKIP, 24'sd0, 24'sd0, now_ms, 24'd0);
    send_item(FUNC_SAMPLE, 24'sd0, 24'sd0, now_ms + interval_reg, 24'd77); // exactly interval
    timed_sample(24'sd0, 24'sd0, 24'd77, 1);
    timed_sample(24'sd0, 24'sd0, 24'd77, 1);                   // zero distance
  endtask

  task automatic test_factor_cases();
    write_reg(CFG_INTERVAL, 16'd0);
    write_reg(CFG_FACTOR, 16'd1024);
    timed_sample(24'sd0, 24'sd0, 24'd900, 1000);
    timed_sample(24'sd256, 24'sd0, 24'd900, 1000);             // factor-only violation
    timed_sample(24'sd0, 24'sd0, 24'd900, 1);                  // elapsed of one ms
    write_reg(CFG_FACTOR, 16'd0);
    timed_sample(-24'sh800000, -24'sh800000, 24'd900, 1);
    write_reg(CFG_INTERVAL, 16'd1000);
    write_reg(CFG_FACTOR, 16'd256);
  endtask

  task automatic random_stretch(input int count);
    int sel;
    logic signed [CW-1:0] dx, dy;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      dx  = CW'($signed($urandom_range(0, 8192)) - 4096);
      dy  = CW'($signed($urandom_range(0, 8192)) - 4096);
      if (sel < 70) begin
        cur_x += dx;
        cur_y += dy;
        timed_sample(cur_x, cur_y, cur_allowed,
                     ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 2000));
      end else if (sel < 78) begin
        cur_allowed = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6000));
        timed_sample(cur_x, cur_y, cur_allowed, $urandom_range(1, 2000));
      end else if (sel < 84) begin
        send_item(FUNC_SAMPLE, CW'($urandom), CW'($urandom),
                  now_ms - 31'($urandom_range(0, (now_ms > 3000) ? 3000 : now_ms)), cur_allowed);
      end else if (sel < 88) begin
        send_item(FUNC_SPEED, CW'($urandom), CW'($urandom), 31'($urandom), 24'($urandom));
      end else if (sel < 92) begin
        send_item(FUNC_NONE, CW'($urandom), CW'($urandom), 31'($urandom), 24'($urandom));
      end else if (sel < 96) begin
        now_ms = now_ms + 31'($urandom_range(0, 3000));
        send_item(FUNC_SKIP, CW'($urandom), CW'($urandom), now_ms, 24'($urandom));
      end else begin
        cur_x = CW'($urandom);
        cur_y = CW'($urandom);
        timed_sample(cur_x, cur_y, cur_allowed, $urandom_range(1, 500));
      end
    end
  endtask

  task automatic test_random_settings();
    cur_x = '0;
    cur_y = '0;
    cur_allowed = 24'd2000;
    random_stretch(250);
    write_reg(CFG_INTERVAL, 16'd0);
    quiet = 1;
    random_stretch(100);
    quiet = 0;
    write_reg(CFG_FACTOR, 16'd0);
    random_stretch(150);
    write_reg(CFG_INTERVAL, 16'hffff);
    write_reg(CFG_FACTOR, 16'hffff);
    random_stretch(400);                                       // drives threat to saturation
    write_reg(CFG_INTERVAL, 16'($urandom_range(0, 5000)));
    write_reg(CFG_FACTOR, 16'($urandom_range(64, 1024)));
    random_stretch(350);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (400) @(negedge clk);
        hold_rx = 0;
      end
    join_none
    random_stretch(40);
  endtask

  task automatic test_stamp_extremes();
    wait (expected_reports.size() == 0);
    now_ms = 31'h7fff_ffff;
    send_item(FUNC_SKIP, '0, '0, now_ms, '0);
    send_item(FUNC_SAMPLE, 24'sh7fffff, 24'sh7fffff, now_ms, '1);   // equal to max stamp
    send_item(FUNC_SAMPLE, '0, '0, 31'd0, '0);                       // far in the past
  endtask

  initial begin
    interval_reg = 16'd1000;
    factor_reg   = 16'd256;
    mdl_stamp   = '0;
    last_x       = '0;
    last_y       = '0;
    last_allowed = '0;
    threat_cnt   = '0;
    peak_excess  = '0;
    have_pos     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_basics();
    test_factor_cases();
    test_random_settings();
    test_backpressure();
    test_stamp_extremes();
    wait (expected_reports.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d items (%0d evaluated, %0d violations), %0d register writes,",
             n_items, n_eval, n_viol, n_cfg);
    $display("interval and factor extremes, receiver hold-off and stamp limits.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
